// ===== rtl/core/periodic_report_scheduler_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the periodic report scheduler
// Concurrent assertion wrappers that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_REPORT_SCHEDULER_MACROS_SVH
`define PERIODIC_REPORT_SCHEDULER_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define PRS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("periodic_report_scheduler assertion failed");
// Expression must never be true outside reset.
`define PRS_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("periodic_report_scheduler forbidden condition");
`else
`define PRS_ASSERT(lbl, clk, rst_n, prop)
`define PRS_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== rtl/core/prs_pkg.sv =====
// ----------------------------------------------------------------------------
// Periodic report scheduler package
// Shared constants, controller states and controller/datapath interface types.
// ----------------------------------------------------------------------------
package prs_pkg;

	// Period limits and unit conversion.
	localparam logic [15:0] MIN_PERIOD_MS = 16'd100;
	localparam logic [15:0] MAX_PERIOD_MS = 16'd60000;
	localparam logic [9:0]  US_PER_MS     = 10'd1000;
	localparam int unsigned PERIOD_US_W   = 26;
	localparam int unsigned TIME_W        = 64;
	localparam int unsigned SID_W         = 32;
	localparam int unsigned ACK_W         = 16;

	// Result kind codes.
	localparam logic KIND_ACK    = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	// Input command codes.
	localparam logic CMD_TICK    = 1'b0;
	localparam logic CMD_REQUEST = 1'b1;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_R_SCAN,
		ST_R_ACK,
		ST_R_RPT,
		ST_T_CHECK,
		ST_T_DIV,
		ST_T_SCAN,
		ST_T_EMIT
	} state_t;

	// Which result the datapath loads into the output register.
	typedef enum logic [1:0] {
		EMIT_ACK,
		EMIT_REQ_RPT,
		EMIT_TICK_RPT
	} emit_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      latch_in;
		logic      idx_clr;
		logic      idx_inc;
		logic      req_step;
		logic      req_commit;
		logic      req_remove;
		logic      due_clr;
		logic      div_start;
		logic      tick_update;
		logic      min_clr;
		logic      min_step;
		logic      emit;
		emit_sel_t emit_sel;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic idx_last;
		logic zero;
		logic found;
		logic due_now;
		logic div_done;
		logic due_none;
		logic due_one;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/core/prs_div.sv =====
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring bit-serial division giving a 64-bit dividend modulo a 26-bit divisor.
// ----------------------------------------------------------------------------
module prs_div
	import prs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [TIME_W-1:0]      dividend,
	input  logic [PERIOD_US_W-1:0] divisor,
	output logic                   busy,
	output logic                   done,
	output logic [PERIOD_US_W-1:0] rem
);

	localparam int unsigned CNT_W = $clog2(TIME_W + 1);

	logic [TIME_W-1:0]      dvd_q;
	logic [PERIOD_US_W-1:0] div_q;
	logic [PERIOD_US_W-1:0] rem_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [PERIOD_US_W:0]   trial;
	logic [PERIOD_US_W:0]   diff;

	// One quotient bit per cycle: shift in the next dividend bit and subtract if it fits.
	always_comb begin
		trial = {rem_q, dvd_q[TIME_W-1]};
		diff  = trial - {1'b0, div_q};
	end

	// Control of the iteration count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(TIME_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and dividend shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[TIME_W-2:0], 1'b0};
			if (!diff[PERIOD_US_W]) begin
				rem_q <= diff[PERIOD_US_W-1:0];
			end else begin
				rem_q <= trial[PERIOD_US_W-1:0];
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/core/prs_dp.sv =====
// ----------------------------------------------------------------------------
// Periodic report scheduler datapath
// Subscription table, request search, due check, alignment and output register.
// ----------------------------------------------------------------------------
`include "periodic_report_scheduler_macros.svh"
module prs_dp
	import prs_pkg::*;
#(
	parameter int unsigned MAX_SESSIONS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output status_t              status,
	input  logic [SID_W-1:0]     in_session_id,
	input  logic [SID_W-1:0]     in_period_ms,
	input  logic [TIME_W-1:0]    in_now_us,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic                 out_kind,
	output logic [SID_W-1:0]     out_session_id,
	output logic [ACK_W-1:0]     out_ack_period_ms,
	output logic                 out_last
);

	localparam int unsigned IW = (MAX_SESSIONS > 1) ? $clog2(MAX_SESSIONS) : 1;
	localparam int unsigned CW = $clog2(MAX_SESSIONS + 1);

	// Latched input item.
	logic [SID_W-1:0]  sid_q;
	logic [ACK_W-1:0]  per_q;
	logic              zero_q;
	logic [TIME_W-1:0] now_q;

	// Subscription table.
	logic                   valid_q   [MAX_SESSIONS];
	logic [SID_W-1:0]       sess_q    [MAX_SESSIONS];
	logic [PERIOD_US_W-1:0] per_us_q  [MAX_SESSIONS];
	logic [TIME_W-1:0]      last_us_q [MAX_SESSIONS];
	logic                   due_q     [MAX_SESSIONS];
	logic [CW-1:0]          due_cnt_q;

	// Walk index and search results.
	logic [IW-1:0]    idx_q;
	logic             hit_q;
	logic [IW-1:0]    hit_idx_q;
	logic             free_q;
	logic [IW-1:0]    free_idx_q;
	logic             min_found_q;
	logic [IW-1:0]    min_idx_q;
	logic [SID_W-1:0] min_sid_q;

	// Output register.
	logic             out_valid_q;
	logic             out_kind_q;
	logic [SID_W-1:0] out_sid_q;
	logic [ACK_W-1:0] out_ack_q;
	logic             out_last_q;

	logic [TIME_W-1:0]      dt;
	logic                   due_now;
	logic [IW-1:0]          slot;
	logic [PERIOD_US_W-1:0] commit_per_us;
	logic                   div_busy;
	logic                   div_done;
	logic [PERIOD_US_W-1:0] div_rem;
	logic                   out_free;
	logic                   found;
	logic [ACK_W-1:0]       clamp;

	// Elapsed time of the entry under the walk index.
	always_comb begin
		dt      = now_q - last_us_q[idx_q];
		due_now = valid_q[idx_q] && (dt >= {{(TIME_W-PERIOD_US_W){1'b0}}, per_us_q[idx_q]});
	end

	// Requested period clamped to the allowed range.
	always_comb begin
		priority if (in_period_ms < {16'd0, MIN_PERIOD_MS}) begin
			clamp = MIN_PERIOD_MS;
		end else if (in_period_ms > {16'd0, MAX_PERIOD_MS}) begin
			clamp = MAX_PERIOD_MS;
		end else begin
			clamp = in_period_ms[ACK_W-1:0];
		end
	end

	assign found         = hit_q || free_q;
	assign slot          = hit_q ? hit_idx_q : free_idx_q;
	assign commit_per_us = PERIOD_US_W'({10'd0, per_q} * {16'd0, US_PER_MS});
	assign out_free      = !out_valid_q || out_ready;

	// Remainder of the elapsed time over the period.
	prs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dt),
		.divisor  (per_us_q[idx_q]),
		.busy     (div_busy),
		.done     (div_done),
		.rem      (div_rem)
	);

	// Input latch.
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			sid_q  <= in_session_id;
			per_q  <= clamp;
			zero_q <= (in_period_ms == '0);
			now_q  <= in_now_us;
		end
	end

	// Walk index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + IW'(1);
		end
	end

	// Request search for a matching session and the lowest free slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (cmd.latch_in) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (cmd.req_step) begin
			if (valid_q[idx_q] && (sess_q[idx_q] == sid_q)) begin
				hit_q <= 1'b1;
			end
			if (!valid_q[idx_q] && !free_q) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.req_step) begin
			if (valid_q[idx_q] && (sess_q[idx_q] == sid_q)) begin
				hit_idx_q <= idx_q;
			end
			if (!valid_q[idx_q] && !free_q) begin
				free_idx_q <= idx_q;
			end
		end
	end

	// Valid and due flags with the count of pending reports.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SESSIONS; i++) begin
				valid_q[i] <= 1'b0;
				due_q[i]   <= 1'b0;
			end
			due_cnt_q <= '0;
		end else begin
			if (cmd.req_commit) begin
				valid_q[slot] <= 1'b1;
			end
			if (cmd.req_remove && hit_q) begin
				valid_q[hit_idx_q] <= 1'b0;
			end
			if (cmd.due_clr) begin
				for (int i = 0; i < MAX_SESSIONS; i++) begin
					due_q[i] <= 1'b0;
				end
				due_cnt_q <= '0;
			end else if (cmd.tick_update) begin
				due_q[idx_q] <= 1'b1;
				due_cnt_q    <= due_cnt_q + CW'(1);
			end else if (cmd.emit && (cmd.emit_sel == EMIT_TICK_RPT)) begin
				due_q[min_idx_q] <= 1'b0;
				due_cnt_q        <= due_cnt_q - CW'(1);
			end
		end
	end

	// Entry payload: written on commit, last-update time aligned on a due tick.
	always_ff @(posedge clk) begin
		if (cmd.req_commit) begin
			sess_q[slot]    <= sid_q;
			per_us_q[slot]  <= commit_per_us;
			last_us_q[slot] <= now_q;
		end else if (cmd.tick_update) begin
			last_us_q[idx_q] <= now_q - {{(TIME_W-PERIOD_US_W){1'b0}}, div_rem};
		end
	end

	// Search for the lowest session id among the pending reports.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_found_q <= 1'b0;
		end else if (cmd.min_clr) begin
			min_found_q <= 1'b0;
		end else if (cmd.min_step && due_q[idx_q]) begin
			min_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.min_step && due_q[idx_q] && (!min_found_q || (sess_q[idx_q] < min_sid_q))) begin
			min_idx_q <= idx_q;
			min_sid_q <= sess_q[idx_q];
		end
	end

	// Output register, refilled when empty or when its transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			unique case (cmd.emit_sel)
				EMIT_ACK: begin
					out_kind_q <= KIND_ACK;
					out_sid_q  <= sid_q;
					out_ack_q  <= (zero_q || !found) ? '0 : per_q;
					out_last_q <= zero_q || !found;
				end
				EMIT_REQ_RPT: begin
					out_kind_q <= KIND_REPORT;
					out_sid_q  <= sid_q;
					out_ack_q  <= '0;
					out_last_q <= 1'b1;
				end
				EMIT_TICK_RPT: begin
					out_kind_q <= KIND_REPORT;
					out_sid_q  <= min_sid_q;
					out_ack_q  <= '0;
					out_last_q <= (due_cnt_q == CW'(1));
				end
				default: begin
					out_kind_q <= KIND_ACK;
					out_sid_q  <= sid_q;
					out_ack_q  <= '0;
					out_last_q <= 1'b1;
				end
			endcase
		end
	end

	// Status toward the controller.
	always_comb begin
		status.idx_last = (idx_q == IW'(MAX_SESSIONS - 1));
		status.zero     = zero_q;
		status.found    = found;
		status.due_now  = due_now;
		status.div_done = div_done;
		status.due_none = (due_cnt_q == '0);
		status.due_one  = (due_cnt_q == CW'(1));
		status.out_free = out_free;
	end

	assign out_valid         = out_valid_q;
	assign out_kind          = out_kind_q;
	assign out_session_id    = out_sid_q;
	assign out_ack_period_ms = out_ack_q;
	assign out_last          = out_last_q;

	// The remainder unit is started only when idle.
	`PRS_ASSERT(a_div_start_idle, clk, arst_n, cmd.div_start |-> !div_busy)
	// A result is loaded only into a free output register.
	`PRS_ASSERT(a_emit_free, clk, arst_n, cmd.emit |-> out_free)
	// A tick report is emitted only after a pending entry was found.
	`PRS_ASSERT_NEVER(a_tick_rpt_found, clk, arst_n,
		cmd.emit && (cmd.emit_sel == EMIT_TICK_RPT) && (!min_found_q || status.due_none))
	// An entry is committed only to a slot the search turned up.
	`PRS_ASSERT(a_commit_found, clk, arst_n, cmd.req_commit |-> found)

endmodule

// ===== rtl/core/prs_ctrl.sv =====
// ----------------------------------------------------------------------------
// Periodic report scheduler controller
// Sequences request search, tick walk, remainder runs and result emission.
// ----------------------------------------------------------------------------
module prs_ctrl
	import prs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_command,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (in_command == CMD_REQUEST) ? ST_R_SCAN : ST_T_CHECK;
				end
			end
			ST_R_SCAN: begin
				if (status.idx_last) begin
					state_d = ST_R_ACK;
				end
			end
			ST_R_ACK: begin
				if (status.out_free) begin
					state_d = (!status.zero && status.found) ? ST_R_RPT : ST_IDLE;
				end
			end
			ST_R_RPT: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_T_CHECK: begin
				if (status.due_now) begin
					state_d = ST_T_DIV;
				end else if (status.idx_last) begin
					state_d = status.due_none ? ST_IDLE : ST_T_SCAN;
				end
			end
			ST_T_DIV: begin
				if (status.div_done) begin
					state_d = status.idx_last ? ST_T_SCAN : ST_T_CHECK;
				end
			end
			ST_T_SCAN: begin
				if (status.idx_last) begin
					state_d = ST_T_EMIT;
				end
			end
			ST_T_EMIT: begin
				if (status.out_free) begin
					state_d = status.due_one ? ST_IDLE : ST_T_SCAN;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath commands.
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					cmd.idx_clr  = 1'b1;
					cmd.due_clr  = 1'b1;
				end
			end
			ST_R_SCAN: begin
				cmd.req_step = 1'b1;
				cmd.idx_inc  = !status.idx_last;
			end
			ST_R_ACK: begin
				cmd.emit_sel = EMIT_ACK;
				if (status.out_free) begin
					cmd.emit       = 1'b1;
					cmd.req_remove = status.zero;
					cmd.req_commit = !status.zero && status.found;
				end
			end
			ST_R_RPT: begin
				cmd.emit_sel = EMIT_REQ_RPT;
				cmd.emit     = status.out_free;
			end
			ST_T_CHECK: begin
				if (status.due_now) begin
					cmd.div_start = 1'b1;
				end else if (status.idx_last) begin
					cmd.idx_clr = 1'b1;
					cmd.min_clr = 1'b1;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ST_T_DIV: begin
				if (status.div_done) begin
					cmd.tick_update = 1'b1;
					cmd.idx_clr     = status.idx_last;
					cmd.min_clr     = status.idx_last;
					cmd.idx_inc     = !status.idx_last;
				end
			end
			ST_T_SCAN: begin
				cmd.min_step = 1'b1;
				cmd.idx_inc  = !status.idx_last;
			end
			ST_T_EMIT: begin
				cmd.emit_sel = EMIT_TICK_RPT;
				if (status.out_free) begin
					cmd.emit    = 1'b1;
					cmd.idx_clr = 1'b1;
					cmd.min_clr = 1'b1;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== rtl/core/periodic_report_scheduler.sv =====
// ----------------------------------------------------------------------------
// Periodic report scheduler
// Table of periodic report subscriptions keyed by session id.
// ----------------------------------------------------------------------------
// Usage: the slave channel takes one item per transfer. s_tuser is the command
// (0 = time tick, 1 = subscribe request); s_tdata carries session id, period
// in ms and the current time in us. The master channel returns results: m_tuser
// is the kind (0 = ack, 1 = report), m_tlast marks the final result of an item.
// A request first searches the whole table, then returns its ack and, when
// stored, a report. A tick walks the table, one entry a cycle, and each due
// entry holds the walk while the bit-serial remainder unit runs; reports then
// go out in ascending session id, each after a minimum search over the table.
// One item is processed at a time; s_tready is high only between items.
// Reset empties the table at once. When the receiver stalls, the result waits
// in the output register and processing pauses until it is taken.
// ----------------------------------------------------------------------------
module periodic_report_scheduler
	import prs_pkg::*;
#(
	parameter int unsigned MAX_SESSIONS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // session_id[31:0], period_ms[63:32], now_us[127:64]
	input  logic         s_tuser,   // command
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [47:0]  m_tdata,   // session_id_out[31:0], ack_period_ms[47:32]
	output logic         m_tuser,   // kind
	output logic         m_tlast
);

	cmd_t             cmd;
	status_t          status;
	logic [SID_W-1:0] out_sid;
	logic [ACK_W-1:0] out_ack;

	// Sequencer.
	prs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_command (s_tuser),
		.in_ready   (s_tready),
		.status     (status),
		.cmd        (cmd)
	);

	// Table and arithmetic.
	prs_dp #(
		.MAX_SESSIONS (MAX_SESSIONS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.in_session_id     (s_tdata[31:0]),
		.in_period_ms      (s_tdata[63:32]),
		.in_now_us         (s_tdata[127:64]),
		.out_ready         (m_tready),
		.out_valid         (m_tvalid),
		.out_kind          (m_tuser),
		.out_session_id    (out_sid),
		.out_ack_period_ms (out_ack),
		.out_last          (m_tlast)
	);

	assign m_tdata = {out_ack, out_sid};

endmodule
